// File: rtl/hdlcd_pkg.sv
// Shared types, constants and helper functions of the HDLC bit destuffing deframer.
`default_nettype none

package hdlcd_pkg;

  // Largest payload a frame may carry, whatever the register says.
  localparam int MAX_FRAME_BYTES = 256;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd254;

  // Width of the per-frame payload counter and of the limit compare.
  localparam int PAY_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = (PAY_W > CFG_W) ? PAY_W : CFG_W;

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;
  localparam logic [2:0] STUFF_RUN = 3'd5;

  // Result queue depth; kept a power of two so the pointers wrap freely.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_FRAME   = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_STUFF   = 3'd2;
  localparam logic [2:0] ST_PARTIAL = 3'd3;
  localparam logic [2:0] ST_FILL    = 3'd4;
  localparam logic [2:0] ST_NOCLOSE = 3'd5;
  localparam logic [2:0] ST_LONG    = 3'd6;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    logic       frame_end;
    logic [2:0] status;
  } res_t;

  // Deframer state carried from one line byte to the next. All zero is the
  // reset value, with the phase hunting for an opening flag.
  typedef struct packed {
    logic [1:0]       phase;
    logic [2:0]       hunt_cnt;
    logic             lead;
    logic [2:0]       ones_run;
    logic [7:0]       acc;
    logic [2:0]       acc_bits;
    logic [PAY_W-1:0] pay_cnt;
  } dd_state_t;

  // What passes from one bit position to the next inside one line byte.
  typedef struct packed {
    dd_state_t  st;
    logic       closing;
    logic [2:0] close_st;
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
  } step_t;

  function automatic res_t make_event(logic [2:0] st);
    res_t r;
    r.out_byte   = 8'd0;
    r.data_valid = 1'b0;
    r.frame_end  = 1'b1;
    r.status     = st;
    return r;
  endfunction

  function automatic res_t make_data(logic [7:0] b);
    res_t r;
    r.out_byte   = b;
    r.data_valid = 1'b1;
    r.frame_end  = 1'b0;
    r.status     = ST_OK;
    return r;
  endfunction

  // Only the first two results of a line byte are kept.
  function automatic step_t add_result(step_t s, res_t r);
    step_t o;
    o = s;
    if (s.n_res == 2'd0) begin
      o.res0 = r;
    end else if (s.n_res == 2'd1) begin
      o.res1 = r;
    end
    if (s.n_res != 2'd2) begin
      o.n_res = s.n_res + 2'd1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hdlcd_bit_step.sv
// One bit position of the deframer: flag hunt, destuffing and byte packing.
`default_nettype none

module hdlcd_bit_step import hdlcd_pkg::*; (
  input  logic             bit_in,
  input  logic [CMP_W-1:0] limit,
  input  step_t            step_in,
  output step_t            step_out
);

  logic [2:0]  ncommit;
  logic [5:0]  pat;
  logic [13:0] tcat;
  logic [3:0]  total;
  logic        full;
  logic [7:0]  done_byte;
  logic        too_long;

  // Held-back bits are an optional zero followed by ones_run ones. They are
  // appended to the accumulator at once; at most one byte can complete.
  assign ncommit   = {2'b00, step_in.st.lead} + step_in.st.ones_run;
  assign pat       = 6'((7'd1 << step_in.st.ones_run) - 7'd1);
  assign tcat      = ({6'd0, step_in.st.acc} << ncommit) | {8'd0, pat};
  assign total     = {1'b0, step_in.st.acc_bits} + {1'b0, ncommit};
  assign full      = total[3];
  assign done_byte = 8'(tcat >> total[2:0]);
  assign too_long  = CMP_W'(step_in.st.pay_cnt) >= limit;

  always_comb begin
    step_out = step_in;
    if (step_in.closing) begin
      // The rest of the byte after a closing flag must be ones.
      if (!bit_in) begin
        step_out.close_st = ST_FILL;
      end
    end else begin
      unique case (step_in.st.phase)
        PH_HUNT: begin
          if (step_in.st.hunt_cnt == 3'd0) begin
            if (!bit_in) begin
              step_out.st.hunt_cnt = 3'd1;
            end
          end else if (bit_in != FLAG_PATTERN[~step_in.st.hunt_cnt]) begin
            step_out = add_result(step_in, make_event(ST_IDLE));
            step_out.st.phase    = PH_DISCARD;
            step_out.st.hunt_cnt = 3'd0;
          end else if (&step_in.st.hunt_cnt) begin
            step_out.st.phase    = PH_FRAME;
            step_out.st.hunt_cnt = 3'd0;
            step_out.st.lead     = 1'b0;
            step_out.st.ones_run = 3'd0;
            step_out.st.acc      = 8'd0;
            step_out.st.acc_bits = 3'd0;
            step_out.st.pay_cnt  = '0;
          end else begin
            step_out.st.hunt_cnt = step_in.st.hunt_cnt + 3'd1;
          end
        end
        PH_FRAME: begin
          if (step_in.st.ones_run > STUFF_RUN) begin
            if (!bit_in) begin
              step_out.closing     = 1'b1;
              step_out.close_st    = (step_in.st.acc_bits != 3'd0) ? ST_PARTIAL : ST_OK;
              step_out.st.lead     = 1'b0;
              step_out.st.ones_run = 3'd0;
            end else begin
              step_out = add_result(step_in, make_event(ST_STUFF));
              step_out.st.phase = PH_DISCARD;
            end
          end else if (!bit_in) begin
            if (full) begin
              if (too_long) begin
                step_out = add_result(step_in, make_event(ST_LONG));
                step_out.st.phase = PH_DISCARD;
              end else begin
                step_out = add_result(step_in, make_data(done_byte));
                step_out.st.pay_cnt = PAY_W'(step_in.st.pay_cnt + 1'b1);
              end
            end
            step_out.st.acc      = tcat[7:0];
            step_out.st.acc_bits = total[2:0];
            // A zero after five ones is stuffing and is dropped.
            step_out.st.lead     = (step_in.st.ones_run != STUFF_RUN);
            step_out.st.ones_run = 3'd0;
          end else begin
            step_out.st.ones_run = step_in.st.ones_run + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/hdlcd_core.sv
// Input register, deframer state and the eight-bit step chain for one line byte.
`default_nettype none

module hdlcd_core import hdlcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_stream,
  input  logic [CMP_W-1:0] limit,
  input  logic             room,
  output logic [1:0]       res_n,
  output res_t             res0,
  output res_t             res1
);

  logic       in_v;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       fire;

  dd_state_t state;
  dd_state_t state_next;
  step_t     chain [0:8];
  step_t     fin;

  assign fire     = in_v && room;
  assign in_ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
      in_eos  <= end_of_stream;
    end
  end

  always_comb begin
    chain[0]          = '0;
    chain[0].st       = state;
    chain[0].close_st = ST_OK;
  end

  for (genvar i = 0; i < 8; i++) begin : g_bit
    hdlcd_bit_step u_step (
      .bit_in   (in_byte[7-i]),
      .limit    (limit),
      .step_in  (chain[i]),
      .step_out (chain[i+1])
    );
  end

  always_comb begin
    fin = chain[8];
    if (chain[8].closing) begin
      fin    = add_result(chain[8], make_event(chain[8].close_st));
      fin.st = '0;
      if (chain[8].close_st != ST_OK) begin
        fin.st.phase = PH_DISCARD;
      end
    end
    // End of stream replaces the results when a frame or flag is left open.
    if (in_eos) begin
      if (fin.st.phase == PH_FRAME) begin
        fin.n_res = 2'd1;
        fin.res0  = make_event(ST_NOCLOSE);
      end else if (fin.st.phase == PH_HUNT && fin.st.hunt_cnt != 3'd0) begin
        fin.n_res = 2'd1;
        fin.res0  = make_event(ST_IDLE);
      end
      fin.st = '0;
    end
  end

  assign state_next = fire ? fin.st : state;
  assign res_n      = fire ? fin.n_res : 2'd0;
  assign res0       = fin.res0;
  assign res1       = fin.res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

  a_no_res_without_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |-> res_n == 2'd0)
    else $error("results produced without a word being processed");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_eos |=> state.phase == PH_HUNT && state.hunt_cnt == 3'd0 &&
                       state.ones_run == 3'd0 && state.acc_bits == 3'd0)
    else $error("state not cleared after end of stream");

  a_ones_bound: assert property (@(posedge clk) disable iff (rst)
    state.ones_run != 3'd7)
    else $error("run of ones beyond the flag length");

endmodule

`default_nettype wire

// File: rtl/hdlcd_res_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
`default_nettype none

module hdlcd_res_fifo import hdlcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_n,
  input  res_t       wr0,
  input  res_t       wr1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       head
);

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W:0]   count;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  // Room for a full pair of results, not counting a read in the same cycle.
  assign room      = (count <= (RES_PTR_W+1)'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[RES_PTR_W'(wr_ptr + 1'b1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= RES_PTR_W'(wr_ptr + wr_n);
      if (pop) begin
        rd_ptr <= RES_PTR_W'(rd_ptr + 1'b1);
      end
      count <= (RES_PTR_W+1)'(count + wr_n - pop);
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    !room |-> wr_n == 2'd0)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (RES_PTR_W+1)'(RES_DEPTH))
    else $error("result queue overflow");

  a_head_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rd_ptr))
    else $error("stalled result lost");

endmodule

`default_nettype wire

// File: rtl/hdlc_bit_destuff_deframer.sv
// HDLC bit destuffing deframer, top level.
//
// Input channel (in_valid/in_ready): one received line byte per word, bits
// taken most significant first, with end_of_stream on the last byte.
// Output channel (out_valid/out_ready): one result per word, either a payload
// byte (data_valid) or a frame event (frame_end with status).
// cfg_write_en/cfg_write_data set the longest accepted payload; write it only
// while the block is idle.
// Path: an accepted byte is held in the input register, all eight bits are
// processed once the result queue has room for two entries, and its results
// are written into the result queue, whose head drives the output.
// Throughput: one line byte per cycle while the queue has room; a byte with
// two results gives two output words, and the four-entry queue absorbs that.
// If the receiver stalls, the queue fills and in_ready drops once fewer than
// two entries are free; nothing is lost.
// Reset (rst, synchronous) empties the queue, returns to flag hunting and
// loads the payload limit with 254.
`default_nettype none

module hdlc_bit_destuff_deframer import hdlcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_stream,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             data_valid,
  output logic             frame_end,
  output logic [2:0]       status,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data
);

  logic [CFG_W-1:0] max_payload_bytes;
  logic [CMP_W-1:0] limit;
  logic             room;
  logic [1:0]       res_n;
  res_t             res0;
  res_t             res1;
  res_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= CFG_RESET;
    end else if (cfg_write_en) begin
      max_payload_bytes <= cfg_write_data;
    end
  end

  assign limit = (CMP_W'(max_payload_bytes) < CMP_W'(MAX_FRAME_BYTES)) ?
                 CMP_W'(max_payload_bytes) : CMP_W'(MAX_FRAME_BYTES);

  hdlcd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .end_of_stream (end_of_stream),
    .limit         (limit),
    .room          (room),
    .res_n         (res_n),
    .res0          (res0),
    .res1          (res1)
  );

  hdlcd_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_n      (res_n),
    .wr0       (res0),
    .wr1       (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte   = head.out_byte;
  assign data_valid = head.data_valid;
  assign frame_end  = head.frame_end;
  assign status     = head.status;

endmodule

`default_nettype wire

// File: tb/hdlc_deframe_checker.sv
// Checker for the HDLC deframer: predicts every result word and compares it with the output.
module hdlc_deframe_checker import hdlcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_stream,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [7:0]       out_byte,
  input  logic             data_valid,
  input  logic             frame_end,
  input  logic [2:0]       status,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data,
  output int               words_due,
  output int               mismatches
);

  // Predicted deframer state.
  logic [1:0]       ph;
  logic [2:0]       ones_run;
  logic [7:0]       held_bits;
  logic [3:0]       held_cnt;
  logic [7:0]       acc;
  logic [2:0]       acc_bits;
  logic [8:0]       pay_cnt;
  logic [CFG_W-1:0] limit_reg;

  res_t due_results[$];

  function automatic res_t end_word(input logic [2:0] code);
    return {8'd0, 1'b0, 1'b1, code};
  endfunction

  task automatic clear_deframer();
    ph = PH_HUNT;
    ones_run = '0;
    held_bits = '0;
    held_cnt = '0;
    acc = '0;
    acc_bits = '0;
    pay_cnt = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Walks one line byte, most significant bit first, and queues the words it yields.
  task automatic deframe_byte(input logic [7:0] line, input logic eos);
    res_t       step_res[$];
    logic       closing;
    logic [2:0] close_st;
    logic       cur;
    logic       want;
    int         lim;
    closing = 1'b0;
    close_st = ST_OK;
    lim = (limit_reg < MAX_FRAME_BYTES) ? limit_reg : MAX_FRAME_BYTES;
    for (int k = 7; k >= 0; k--) begin
      cur = line[k];
      if (closing) begin
        if (!cur) close_st = ST_FILL;
      end else if (ph == PH_HUNT) begin
        if (held_cnt == 0) begin
          if (!cur) held_cnt = 4'd1;
        end else begin
          want = FLAG_PATTERN[7 - held_cnt];
          if (cur != want) begin
            step_res.push_back(end_word(ST_IDLE));
            ph = PH_DISCARD;
            held_cnt = '0;
          end else begin
            held_cnt++;
            if (held_cnt >= 8) begin
              clear_deframer();
              ph = PH_FRAME;
            end
          end
        end
      end else if (ph == PH_FRAME) begin
        if (ones_run > STUFF_RUN) begin
          if (!cur) begin
            closing = 1'b1;
            close_st = (acc_bits != 0) ? ST_PARTIAL : ST_OK;
            held_bits = '0;
            held_cnt = '0;
            ones_run = '0;
          end else begin
            step_res.push_back(end_word(ST_STUFF));
            ph = PH_DISCARD;
          end
        end else if (!cur) begin
          // A zero proves that the held bits were payload.
          for (int i = 0; i < held_cnt && ph == PH_FRAME; i++) begin
            acc = {acc[6:0], held_bits[held_cnt - 1 - i]};
            if (acc_bits == 3'd7) begin
              acc_bits = '0;
              if (pay_cnt >= lim) begin
                step_res.push_back(end_word(ST_LONG));
                ph = PH_DISCARD;
              end else begin
                step_res.push_back({acc, 1'b1, 1'b0, ST_OK});
                pay_cnt++;
              end
            end else begin
              acc_bits++;
            end
          end
          held_bits = '0;
          // After five ones the zero is a stuffed bit and is dropped.
          held_cnt = (ones_run != STUFF_RUN) ? 4'd1 : 4'd0;
          ones_run = '0;
        end else begin
          held_bits = {held_bits[6:0], 1'b1};
          held_cnt++;
          ones_run++;
        end
      end
    end

    if (closing) begin
      step_res.push_back(end_word(close_st));
      clear_deframer();
      if (close_st != ST_OK) ph = PH_DISCARD;
    end

    if (eos) begin
      if (ph == PH_FRAME) begin
        step_res.delete();
        step_res.push_back(end_word(ST_NOCLOSE));
      end else if (ph == PH_HUNT && held_cnt != 0) begin
        step_res.delete();
        step_res.push_back(end_word(ST_IDLE));
      end
      clear_deframer();
    end

    for (int i = 0; i < step_res.size() && i < 2; i++) begin
      due_results.push_back(step_res[i]);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want_word;
    if (rst) begin
      clear_deframer();
      limit_reg = CFG_RESET;
      due_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_write_en) limit_reg = cfg_write_data;
      if (in_valid && in_ready) deframe_byte(rx_byte, end_of_stream);
      if (out_valid && out_ready) begin
        got = {out_byte, data_valid, frame_end, status};
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("word with none expected: byte %02h dv %0b fe %0b st %0d",
                                    out_byte, data_valid, frame_end, status));
        end else begin
          want_word = due_results.pop_front();
          if (got.out_byte !== want_word.out_byte || got.data_valid !== want_word.data_valid ||
              got.frame_end !== want_word.frame_end || got.status !== want_word.status) begin
            report_mismatch($sformatf(
              "got byte %02h dv %0b fe %0b st %0d, want byte %02h dv %0b fe %0b st %0d",
              got.out_byte, got.data_valid, got.frame_end, got.status,
              want_word.out_byte, want_word.data_valid, want_word.frame_end, want_word.status));
          end
        end
      end
    end
    words_due <= due_results.size();
  end

endmodule

// File: tb/tb_hdlc_bit_destuff_deframer.sv
// Testbench top for the HDLC deframer: builds stuffed line streams, drives them and gives the verdict.
module tb_hdlc_bit_destuff_deframer;
  import hdlcd_pkg::*;

  localparam int STALL_CYCLES    = 300;
  localparam int DRAIN_CYCLES    = 6;
  localparam int WORDS_PER_PHASE = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'd0;
  logic             end_of_stream = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_byte;
  logic             data_valid;
  logic             frame_end;
  logic [2:0]       status;
  logic             cfg_write_en = 1'b0;
  logic [CFG_W-1:0] cfg_write_data = '0;

  int   words_due;
  int   mismatches;
  int   send_idle_pct = 11;
  int   rcv_idle_pct = 73;
  logic want_stall = 1'b0;
  int   words_sent = 0;
  int   ones_sent = 0;
  logic line_bits[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hdlc_bit_destuff_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .data_valid     (data_valid),
    .frame_end      (frame_end),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  hdlc_deframe_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .data_valid     (data_valid),
    .frame_end      (frame_end),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .words_due      (words_due),
    .mismatches     (mismatches)
  );

  // Receiver: random back-pressure, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (want_stall) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        want_stall = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    // A word that yields no result may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic put_bits(input logic [7:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) line_bits.push_back(v[i]);
  endtask

  task automatic put_ones(input int n);
    for (int i = 0; i < n; i++) line_bits.push_back(1'b1);
  endtask

  task automatic pad_ones();
    while (line_bits.size() % 8 != 0) line_bits.push_back(1'b1);
  endtask

  task automatic put_flag();
    put_bits(FLAG_PATTERN, 8);
    ones_sent = 0;
  endtask

  // Payload bit with a zero inserted after every run of five ones.
  task automatic put_data_bit(input logic b);
    line_bits.push_back(b);
    if (b) begin
      ones_sent++;
      if (ones_sent == 5) begin
        line_bits.push_back(1'b0);
        ones_sent = 0;
      end
    end else begin
      ones_sent = 0;
    end
  endtask

  task automatic put_payload(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) put_data_bit(v[i]);
  endtask

  // Sends the bit stream as line words; the last one carries end of stream.
  task automatic send_line();
    logic [7:0] b;
    pad_ones();
    while (line_bits.size() > 0) begin
      for (int i = 7; i >= 0; i--) b[i] = line_bits.pop_front();
      send_word(b, line_bits.size() == 0);
    end
  endtask

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'hFF;
    if (r < 35) return FLAG_PATTERN;
    if (r < 40) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // One stream: a few frames, mostly well formed, some broken, then end of stream.
  task automatic send_stream(input int lim_now, input logic long_frame);
    int   frames;
    int   len;
    int   kind;
    int   rem;
    int   tail;
    logic broken;
    broken = 1'b0;
    frames = long_frame ? 1 : $urandom_range(1, 4);
    put_ones($urandom_range(0, 12));
    for (int f = 0; f < frames && !broken; f++) begin
      put_flag();
      kind = long_frame ? 0 : $urandom_range(0, 99);
      if (kind >= 90 && kind < 95) begin
        // Closing flag that reuses the zero of the opening one.
        put_bits(FLAG_PATTERN, 7);
        pad_ones();
        put_ones($urandom_range(0, 9));
        continue;
      end
      if (long_frame) len = 257;
      else if (lim_now <= 8) len = $urandom_range(0, lim_now + 2);
      else len = $urandom_range(0, 8);
      for (int n = 0; n < len; n++) put_payload(pick_payload());
      if (kind < 60) begin
        put_flag();
        pad_ones();
        put_ones($urandom_range(0, 9));
      end else if (kind < 68) begin
        rem = $urandom_range(1, 7);
        for (int n = 0; n < rem; n++) put_data_bit($urandom_range(0, 1));
        put_flag();
        broken = 1'b1;
      end else if (kind < 76) begin
        put_flag();
        rem = (8 - line_bits.size() % 8) % 8;
        if (rem > 0) begin
          put_bits(8'($urandom_range(0, 255)), rem);
          line_bits[line_bits.size() - 1 - $urandom_range(0, rem - 1)] = 1'b0;
        end
        broken = 1'b1;
      end else if (kind < 83) begin
        put_bits(8'h00, 1);
        put_ones(7);
        broken = 1'b1;
      end else if (kind < 90) begin
        broken = 1'b1;
      end else begin
        put_bits(8'($urandom_range(0, 255)), 8);
        put_bits(8'($urandom_range(0, 255)), $urandom_range(0, 8));
        broken = 1'b1;
      end
    end
    if (!broken) begin
      tail = $urandom_range(0, 99);
      if (tail < 10) begin
        put_bits(8'h00, 1);
        put_ones($urandom_range(0, 5));
      end else if (tail < 15) begin
        put_bits(8'h00, 2);
      end
    end
    send_line();
  endtask

  initial begin
    logic [8:0]       directed_words[$];
    logic [CFG_W-1:0] limit_plan[$];
    int               target;
    int               noise_len;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Each entry is {end of stream, line byte}.
    directed_words = '{9'h0FF, 9'h100,           // zero that does not start a flag
                       9'h1FF,                   // idle line only
                       9'h07E, 9'h17E,           // empty frame
                       9'h07E, 9'h1FD,           // empty frame with a shared zero
                       9'h07E, 9'h1FC,           // bad fill after the closing flag
                       9'h07E, 9'h03F, 9'h100,   // bad fill over a partial byte
                       9'h07E, 9'h007, 9'h1EF,   // partial byte
                       9'h07E, 9'h1FF,           // seventh one
                       9'h07E, 9'h000, 9'h100,   // no closing flag
                       9'h1FE};                  // opening flag cut off by end of stream
    foreach (directed_words[i]) send_word(directed_words[i][7:0], directed_words[i][8]);
    put_flag();
    put_payload(8'h00);
    put_payload(8'hFF);
    put_flag();
    send_line();

    limit_plan = '{9'd0, 9'd1, 9'd3, 9'd511, 9'd256, 9'd2};
    foreach (limit_plan[seg]) begin
      wait_drained();
      write_limit(limit_plan[seg]);
      send_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 73 : 0;
      rcv_idle_pct  = (seg < 2) ? 73 : (seg < 4) ? 11 : 0;
      target = words_sent + WORDS_PER_PHASE;
      // The register above the hard limit still caps a frame at 256 bytes.
      if (limit_plan[seg] == 9'd511) send_stream(limit_plan[seg], 1'b1);
      if (seg == 4) want_stall = 1'b1;
      while (words_sent < target) begin
        if ($urandom_range(0, 99) < 5) begin
          noise_len = $urandom_range(3, 8);
          for (int n = 0; n < noise_len; n++) put_bits(8'($urandom_range(0, 255)), 8);
          send_line();
        end else begin
          send_stream(limit_plan[seg], 1'b0);
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hdlcd_pkg.sv
rtl/hdlcd_bit_step.sv
rtl/hdlcd_core.sv
rtl/hdlcd_res_fifo.sv
rtl/hdlc_bit_destuff_deframer.sv
tb/hdlc_deframe_checker.sv
tb/tb_hdlc_bit_destuff_deframer.sv
